FILE: rtl/adtd_pkg.sv
`default_nettype none

package adtd_pkg;

    // Converter resolution; every count width and scaling product follows from it.
    localparam int ADC_BITS = 12;

    // Hundredths of a degree at full scale: 5 V at 10 mV per degree.
    localparam int HUND_FULL_SCALE  = 50000;
    // Whole degrees at full scale.
    localparam int WHOLE_FULL_SCALE = 500;

    localparam int HUND_W  = 16;  // hundredths, up to 49999
    localparam int WHOLE_W = 9;   // whole degrees, up to 499
    localparam int FRAC_W  = 7;   // hundredths within a degree, up to 99
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 6;
    localparam int LEAD_W  = 8;

    localparam int HUND_PROD_W  = ADC_BITS + HUND_W;
    localparam int WHOLE_PROD_W = ADC_BITS + WHOLE_W;

    // Largest whole part shown after a minus sign.
    localparam logic [WHOLE_W-1:0] NEG_WHOLE_LIMIT = WHOLE_W'(99);
    localparam logic [FRAC_W-1:0]  FRAC_LIMIT      = FRAC_W'(99);

    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
    localparam logic [LEAD_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [LEAD_W-1:0] CHAR_SPACE = 8'h20;

    // Scaled value between the two pipeline halves.
    typedef struct packed {
        logic               neg;
        logic               over;
        logic [WHOLE_W-1:0] whole;
        logic [FRAC_W-1:0]  frac;
    } t_scaled;

    // floor(x / 10) for x below 512, by reciprocal multiply.
    function automatic logic [5:0] div10(input logic [WHOLE_W-1:0] x);
        logic [16:0] prod;
        prod = {8'd0, x} * 17'd205;
        return prod[16:11];
    endfunction

    function automatic logic [CHAR_W-1:0] to_char(input logic [DIGIT_W-1:0] d);
        return ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, d};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/adc_difference_to_temp_digits.sv
`default_nettype none

// Temperature readout: two ADC counts in, five display characters out.
//
// Input channel: i_valid / o_stall carry one beat of i_pos_count and
// i_neg_count. Output channel: o_valid / i_stall carry one beat of the lead,
// tens, ones, tenths and hundredths characters plus o_over_range.
// A beat moves at a rising edge with valid high and stall low.
//
// Pipeline: three register stages (input, scaled value, characters); a beat
// accepted into the input registers passes through the scaled-value registers
// to the character registers. Throughput: one beat per cycle while i_stall is low.
//
// Each stage holds while it is full and the stage after it stalls, so
// back-pressure from i_stall travels back to o_stall in the same cycle and
// nothing is dropped; held outputs keep their values.
//
// Reset (i_rst_n low at a clock edge) empties every stage; the data
// registers keep whatever they held and are ignored until refilled.
// A negative reading beyond 99.99 is shown as -99.99 with o_over_range set.
module adc_difference_to_temp_digits
    import adtd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [ADC_BITS-1:0]  i_pos_count,
    input  wire logic [ADC_BITS-1:0]  i_neg_count,

    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [LEAD_W-1:0]         o_lead_char,
    output logic [CHAR_W-1:0]         o_tens_char,
    output logic [CHAR_W-1:0]         o_ones_char,
    output logic [CHAR_W-1:0]         o_tenths_char,
    output logic [CHAR_W-1:0]         o_hundredths_char,
    output logic                      o_over_range
);

    // ---------------------------------------------------------------
    // Stage valids and hold chain
    // ---------------------------------------------------------------
    logic r_in_valid, r_mid_valid, r_out_valid;
    logic hold_in, hold_mid, hold_out;

    assign hold_out = r_out_valid & i_stall;
    assign hold_mid = r_mid_valid & hold_out;
    assign hold_in  = r_in_valid  & hold_mid;

    assign o_stall = hold_in;
    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!hold_in)  r_in_valid  <= i_valid;
            if (!hold_mid) r_mid_valid <= r_in_valid;
            if (!hold_out) r_out_valid <= r_mid_valid;
        end
    end

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    logic [ADC_BITS-1:0] r_pos, r_neg;

    always_ff @(posedge i_clk) begin
        if (!hold_in) begin
            r_pos <= i_pos_count;
            r_neg <= i_neg_count;
        end
    end

    // ---------------------------------------------------------------
    // Difference and scaling
    // whole = floor(|d| * 500 / 2^ADC_BITS), equal to floor(hundredths / 100)
    // ---------------------------------------------------------------
    logic                    neg;
    logic [ADC_BITS-1:0]     mag;
    logic [HUND_PROD_W-1:0]  hund_prod;
    logic [WHOLE_PROD_W-1:0] whole_prod;
    logic [HUND_W-1:0]       hund;
    logic [WHOLE_W-1:0]      whole;
    logic [HUND_W-1:0]       whole_x100;
    t_scaled                 n_mid;
    t_scaled                 r_mid;

    always_comb begin
        neg        = r_neg > r_pos;
        mag        = neg ? (r_neg - r_pos) : (r_pos - r_neg);
        hund_prod  = {{HUND_W{1'b0}}, mag} * HUND_PROD_W'(HUND_FULL_SCALE);
        whole_prod = {{WHOLE_W{1'b0}}, mag} * WHOLE_PROD_W'(WHOLE_FULL_SCALE);
        hund       = hund_prod[HUND_PROD_W-1:ADC_BITS];
        whole      = whole_prod[WHOLE_PROD_W-1:ADC_BITS];
        whole_x100 = {{(HUND_W-WHOLE_W){1'b0}}, whole} * HUND_W'(100);

        n_mid.neg   = neg;
        n_mid.over  = 1'b0;
        n_mid.whole = whole;
        // remainder is below 100, so the low bits suffice
        n_mid.frac  = hund[FRAC_W-1:0] - whole_x100[FRAC_W-1:0];
        if (neg && (whole > NEG_WHOLE_LIMIT)) begin
            n_mid.over  = 1'b1;
            n_mid.whole = NEG_WHOLE_LIMIT;
            n_mid.frac  = FRAC_LIMIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!hold_mid) r_mid <= n_mid;
    end

    // ---------------------------------------------------------------
    // Digit split and character forming
    // ---------------------------------------------------------------
    logic [5:0]          whole_div10;
    logic [5:0]          hund_q;
    logic [5:0]          tenths_q;
    logic [9:0]          whole_div10_x10;
    logic [9:0]          hund_x10;
    logic [9:0]          tenths_x10;
    logic [DIGIT_W-1:0]  d_hund, d_tens, d_ones, d_tenths, d_hundredths;
    logic [LEAD_W-1:0]   n_lead;

    always_comb begin
        whole_div10     = div10(r_mid.whole);
        hund_q          = div10({{(WHOLE_W-6){1'b0}}, whole_div10});
        tenths_q        = div10({{(WHOLE_W-FRAC_W){1'b0}}, r_mid.frac});
        whole_div10_x10 = {4'd0, whole_div10} * 10'd10;
        hund_x10        = {4'd0, hund_q} * 10'd10;
        tenths_x10      = {4'd0, tenths_q} * 10'd10;

        d_hund       = hund_q[DIGIT_W-1:0];
        d_tens       = whole_div10[DIGIT_W-1:0] - hund_x10[DIGIT_W-1:0];
        d_ones       = r_mid.whole[DIGIT_W-1:0] - whole_div10_x10[DIGIT_W-1:0];
        d_tenths     = tenths_q[DIGIT_W-1:0];
        d_hundredths = r_mid.frac[DIGIT_W-1:0] - tenths_x10[DIGIT_W-1:0];

        if (r_mid.neg) begin
            n_lead = CHAR_MINUS;
        end else if (hund_q != 6'd0) begin
            n_lead = {{(LEAD_W-CHAR_W){1'b0}}, to_char(d_hund)};
        end else begin
            n_lead = CHAR_SPACE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!hold_out) begin
            o_lead_char       <= n_lead;
            o_tens_char       <= to_char(d_tens);
            o_ones_char       <= to_char(d_ones);
            o_tenths_char     <= to_char(d_tenths);
            o_hundredths_char <= to_char(d_hundredths);
            o_over_range      <= r_mid.over;
        end
    end

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    // a full input stage with room downstream must hand its beat on
    a_in_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !hold_mid |=> r_mid_valid)
        else $error("input stage beat lost");

    // an empty input stage never pushes back
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_stall)
        else $error("stall raised with empty input stage");

    // saturation only ever shows as -99.99; checked on the lead, tens and hundredths
    a_over_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_over_range |-> o_lead_char == CHAR_MINUS
            && o_tens_char == to_char(4'd9) && o_hundredths_char == to_char(4'd9))
        else $error("over-range result not shown as -99.99");

    // every digit character is a decimal digit; checked on the ones and hundredths
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_ones_char >= ASCII_ZERO && o_ones_char <= to_char(4'd9)
            && o_hundredths_char >= ASCII_ZERO
            && o_hundredths_char <= to_char(4'd9))
        else $error("digit character out of range");

endmodule

`default_nettype wire
